// ----- src/tsre_pkg.sv -----
// Package: shared types, codes and helpers of the TCP segment receive engine.
`default_nettype none

package tsre_pkg;

    // Operation codes
    localparam logic [1:0] OP_SEGMENT = 2'd0;
    localparam logic [1:0] OP_PTRS    = 2'd1;
    localparam logic [1:0] OP_LOCAL   = 2'd2;

    // Connection states
    localparam logic [3:0] ST_CLOSED      = 4'd0;
    localparam logic [3:0] ST_LISTEN      = 4'd1;
    localparam logic [3:0] ST_CONNECTING  = 4'd2;
    localparam logic [3:0] ST_SYN_RCVD    = 4'd3;
    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1   = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2   = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT  = 4'd7;
    localparam logic [3:0] ST_CLOSING     = 4'd8;
    localparam logic [3:0] ST_LAST_ACK    = 4'd9;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

    // Header flag bits
    localparam int FL_FIN_BIT = 0;
    localparam int FL_SYN_BIT = 1;
    localparam int FL_RST_BIT = 2;
    localparam int FL_ACK_BIT = 4;
    localparam logic [7:0] FL_SYN_ACK = 8'h12;

    // Persist timer actions
    localparam logic [1:0] PA_NONE  = 2'd0;
    localparam logic [1:0] PA_LOAD  = 2'd1;
    localparam logic [1:0] PA_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MSS       = 2'd0;
    localparam logic [1:0] CFG_QUICK_ACK = 2'd1;
    localparam logic [1:0] CFG_DUP_THR   = 2'd2;
    localparam logic [1:0] CFG_INIT_RWND = 2'd3;

    localparam logic [15:0] MSS_RESET       = 16'd536;
    localparam logic [3:0]  DUP_THR_RESET   = 4'd3;
    localparam logic [15:0] INIT_RWND_RESET = 16'hFFFF;
    localparam logic [31:0] MAX_WINDOW      = 32'd65535;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  header_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] advertised_window;
        logic [15:0] payload_length;
        logic [31:0] new_send_next;
        logic [31:0] new_send_max;
        logic [3:0]  new_conn_state;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  conn_state_out;
        logic [31:0] congestion_window_out;
        logic [31:0] slow_start_threshold_out;
        logic [15:0] send_window_out;
        logic [31:0] receive_next_out;
        logic [31:0] release_up_to;
        logic        release_valid;
        logic        retransmit_request;
        logic        ack_now;
        logic        ack_delayed;
        logic [1:0]  persist_action;
        logic        data_accepted;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        fin;
        logic        rst;
        logic        has_ack;
        logic        syn_ack;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] wnd;
        logic [15:0] len;
        logic [31:0] nsn;
        logic [3:0]  nst;
    } cmd_t;

    typedef struct packed {
        logic        en;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic seq_leq(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_lt(a, b);
    endfunction

endpackage

`default_nettype wire

// ----- src/tsre_front.sv -----
// Front end: classifies incoming items and holds them in a two-entry queue.
`default_nettype none

module tsre_front import tsre_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          q_valid,
    output cmd_t          q_cmd,
    input  wire logic     q_pop
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       cmd;

    always_comb begin
        cmd.op      = s_item.operation;
        cmd.fin     = s_item.header_flags[FL_FIN_BIT];
        cmd.rst     = s_item.header_flags[FL_RST_BIT];
        cmd.has_ack = s_item.header_flags[FL_ACK_BIT];
        cmd.syn_ack = (s_item.header_flags == FL_SYN_ACK);
        cmd.seq     = s_item.seq_number;
        cmd.ack     = s_item.ack_number;
        cmd.wnd     = s_item.advertised_window;
        cmd.len     = s_item.payload_length;
        cmd.nsn     = s_item.new_send_next;
        cmd.nst     = s_item.new_conn_state;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/tsre_div.sv -----
// Iterative 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none

module tsre_div import tsre_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[31]};
        diff      = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 32'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ----- src/tsre_back.sv -----
// Back end: connection state, window and congestion sequencer, result register.
`default_nettype none

module tsre_back import tsre_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_wr_t     cfg,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             div_start,
    output logic [31:0]      div_dividend,
    output logic [31:0]      div_divisor,
    input  wire logic        div_done,
    input  wire logic [31:0] div_quotient,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WIN    = 4'd1;
    localparam logic [3:0] S_ACK    = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_ACKEND = 4'd5;
    localparam logic [3:0] S_DUPFIN = 4'd6;
    localparam logic [3:0] S_DATA   = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    localparam logic MODE_DUP = 1'b0;
    localparam logic MODE_NEW = 1'b1;

    logic [3:0]  state_reg, state_next;
    cmd_t        itm_reg, itm_next;
    logic        mode_reg, mode_next;
    logic        upd_reg, upd_next;

    logic [15:0] mss_reg, mss_next;
    logic        quick_reg, quick_next;
    logic [3:0]  thr_reg, thr_next;
    logic [15:0] irw_reg, irw_next;

    logic [3:0]  cs_reg, cs_next;
    logic [31:0] una_reg, una_next;
    logic [31:0] nxt_reg, nxt_next;
    logic [15:0] swnd_reg, swnd_next;
    logic [31:0] wl1_reg, wl1_next;
    logic [31:0] wl2_reg, wl2_next;
    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ssth_reg, ssth_next;
    logic [15:0] dup_reg, dup_next;
    logic [31:0] rnxt_reg, rnxt_next;
    logic [15:0] rwnd_reg, rwnd_next;

    logic [31:0] diva_reg, diva_next;
    logic [31:0] divb_reg, divb_next;
    logic [31:0] prod_reg, prod_next;

    logic        rel_reg, rel_next;
    logic        rexmit_reg, rexmit_next;
    logic        acknow_reg, acknow_next;
    logic        ackdly_reg, ackdly_next;
    logic [1:0]  persist_reg, persist_next;
    logic        accept_reg, accept_next;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic [15:0] mss_eff;
    logic [3:0]  thr_eff;
    logic        win_upd;
    logic [15:0] dup_inc;
    logic [31:0] c1;
    logic [15:0] min_wnd;
    logic [32:0] sum33;
    logic [31:0] segs;
    logic [16:0] rwnd_sum;
    logic [31:0] seg_end;
    logic [31:0] seg_size;
    logic [31:0] fin_next;
    logic        ack_is;

    assign mss_eff = (mss_reg == 16'd0) ? 16'd1 : mss_reg;
    assign thr_eff = (thr_reg == 4'd0) ? 4'd1 : thr_reg;

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign div_start    = (state_reg == S_DSTART);
    assign div_dividend = diva_reg;
    assign div_divisor  = divb_reg;
    assign m_valid      = out_valid_reg;
    assign m_item       = out_reg;

    always_comb begin
        state_next   = state_reg;
        itm_next     = itm_reg;
        mode_next    = mode_reg;
        upd_next     = upd_reg;
        mss_next     = mss_reg;
        quick_next   = quick_reg;
        thr_next     = thr_reg;
        irw_next     = irw_reg;
        cs_next      = cs_reg;
        una_next     = una_reg;
        nxt_next     = nxt_reg;
        swnd_next    = swnd_reg;
        wl1_next     = wl1_reg;
        wl2_next     = wl2_reg;
        cwnd_next    = cwnd_reg;
        ssth_next    = ssth_reg;
        dup_next     = dup_reg;
        rnxt_next    = rnxt_reg;
        rwnd_next    = rwnd_reg;
        diva_next    = diva_reg;
        divb_next    = divb_reg;
        prod_next    = prod_reg;
        rel_next     = rel_reg;
        rexmit_next  = rexmit_reg;
        acknow_next  = acknow_reg;
        ackdly_next  = ackdly_reg;
        persist_next = persist_reg;
        accept_next  = accept_reg;
        out_valid_next = out_valid_reg;
        out_next     = out_reg;

        win_upd  = seq_lt(wl1_reg, itm_reg.seq) ||
                   ((itm_reg.seq == wl1_reg) && seq_leq(wl2_reg, itm_reg.ack));
        dup_inc  = (dup_reg != 16'hFFFF) ? dup_reg + 16'd1 : dup_reg;
        c1       = ((dup_reg >= {12'd0, thr_eff}) && (cwnd_reg > ssth_reg)) ? ssth_reg : cwnd_reg;
        min_wnd  = ({16'd0, swnd_reg} < cwnd_reg) ? swnd_reg : cwnd_reg[15:0];
        sum33    = 33'd0;
        segs     = (div_quotient < 32'd2) ? 32'd2 : div_quotient;
        rwnd_sum = {1'b0, rwnd_reg} + {1'b0, itm_reg.len};
        seg_end  = itm_reg.seq + {16'd0, itm_reg.len};
        seg_size = seg_end - rnxt_reg;
        fin_next = seg_end + 32'd1;
        ack_is   = (itm_reg.ack == nxt_reg + 32'd1);

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    itm_next     = q_cmd;
                    rel_next     = 1'b0;
                    rexmit_next  = 1'b0;
                    acknow_next  = 1'b0;
                    ackdly_next  = 1'b0;
                    persist_next = PA_NONE;
                    accept_next  = 1'b0;
                    state_next   = S_WIN;
                end
            end
            S_WIN: begin
                state_next = S_EMIT;
                upd_next   = 1'b0;
                case (itm_reg.op)
                    OP_SEGMENT: begin
                        if (cs_reg == ST_CLOSED) begin
                            state_next = S_EMIT;
                        end else if (itm_reg.rst) begin
                            if (cs_reg > ST_CONNECTING) begin
                                cs_next = ST_CLOSED;
                            end
                        end else if (itm_reg.has_ack && (cs_reg != ST_TIME_WAIT)) begin
                            upd_next = 1'b1;
                            if (win_upd) begin
                                swnd_next    = itm_reg.wnd;
                                wl1_next     = itm_reg.seq;
                                wl2_next     = itm_reg.ack;
                                persist_next = (itm_reg.wnd == 16'd0) ? PA_LOAD : PA_CLEAR;
                            end
                            state_next = S_ACK;
                        end else begin
                            state_next = S_DATA;
                        end
                    end
                    OP_PTRS: begin
                        nxt_next = itm_reg.nsn;
                    end
                    OP_LOCAL: begin
                        if (itm_reg.nst <= ST_TIME_WAIT) begin
                            cs_next = itm_reg.nst;
                        end
                        rwnd_next = rwnd_sum[16] ? 16'hFFFF : rwnd_sum[15:0];
                    end
                    default: begin
                    end
                endcase
            end
            S_ACK: begin
                state_next = S_DATA;
                if (seq_leq(itm_reg.ack, una_reg)) begin
                    if (itm_reg.len == 16'd0) begin
                        dup_next = dup_inc;
                        if (dup_inc == {12'd0, thr_eff}) begin
                            diva_next  = {17'd0, min_wnd[15:1]};
                            divb_next  = {16'd0, mss_eff};
                            mode_next  = MODE_DUP;
                            state_next = S_DSTART;
                        end else if (dup_inc > {12'd0, thr_eff}) begin
                            sum33       = {1'b0, cwnd_reg} + {17'd0, mss_eff};
                            cwnd_next   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                            rexmit_next = 1'b1;
                        end
                    end else begin
                        dup_next = 16'd0;
                    end
                end else begin
                    dup_next = 16'd0;
                    una_next = itm_reg.ack;
                    rel_next = 1'b1;
                    if (c1 > ssth_reg) begin
                        cwnd_next  = c1;
                        diva_next  = {16'd0, mss_eff} * {16'd0, mss_eff};
                        divb_next  = c1;
                        mode_next  = MODE_NEW;
                        state_next = S_DSTART;
                    end else begin
                        sum33     = {1'b0, c1} + {17'd0, mss_eff};
                        cwnd_next = (sum33 > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : sum33[31:0];
                    end
                end
            end
            S_DSTART: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_ACKEND;
                end
            end
            S_ACKEND: begin
                if (mode_reg == MODE_DUP) begin
                    ssth_next   = {16'd0, segs[15:0]} * {16'd0, mss_eff};
                    prod_next   = {12'd0, mss_eff * {16'd0, thr_eff}};
                    rexmit_next = 1'b1;
                    state_next  = S_DUPFIN;
                end else begin
                    sum33      = {1'b0, cwnd_reg} + {1'b0, div_quotient};
                    cwnd_next  = (sum33 > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : sum33[31:0];
                    state_next = S_DATA;
                end
            end
            S_DUPFIN: begin
                sum33      = {1'b0, ssth_reg} + {1'b0, prod_reg};
                cwnd_next  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                state_next = S_DATA;
            end
            S_DATA: begin
                // In-order data first; the state switch below may override.
                if (upd_reg && (itm_reg.len != 16'd0)) begin
                    ackdly_next = 1'b1;
                    if (!(seq_leq(seg_end, rnxt_reg) || seq_lt(rnxt_reg, itm_reg.seq))) begin
                        rnxt_next = seg_end;
                        rwnd_next = (seg_size >= {16'd0, rwnd_reg}) ? 16'd0 :
                                    rwnd_reg - seg_size[15:0];
                        if (quick_reg) begin
                            acknow_next = 1'b1;
                        end
                        if (cs_reg <= ST_ESTABLISHED) begin
                            accept_next = 1'b1;
                        end
                    end
                end
                case (cs_reg)
                    ST_CONNECTING: begin
                        if (itm_reg.syn_ack && ack_is) begin
                            cs_next     = ST_ESTABLISHED;
                            rnxt_next   = itm_reg.seq + 32'd1;
                            nxt_next    = itm_reg.ack;
                            swnd_next   = itm_reg.wnd;
                            una_next    = itm_reg.ack;
                            ackdly_next = 1'b1;
                            if (quick_reg) begin
                                acknow_next = 1'b1;
                            end
                        end
                    end
                    ST_SYN_RCVD: begin
                        if (itm_reg.has_ack && ack_is) begin
                            cs_next  = ST_ESTABLISHED;
                            nxt_next = itm_reg.ack;
                        end
                    end
                    ST_ESTABLISHED, ST_CLOSE_WAIT: begin
                        if (itm_reg.fin) begin
                            acknow_next = 1'b1;
                            cs_next     = ST_CLOSE_WAIT;
                            rnxt_next   = fin_next;
                        end
                    end
                    ST_LAST_ACK: begin
                        if (itm_reg.has_ack) begin
                            cs_next = ST_CLOSED;
                        end
                    end
                    ST_FIN_WAIT1: begin
                        if (itm_reg.fin && itm_reg.has_ack && ack_is) begin
                            nxt_next = itm_reg.ack;
                            cs_next  = ST_TIME_WAIT;
                        end else if (itm_reg.fin) begin
                            cs_next = ST_CLOSING;
                        end else if (itm_reg.has_ack && ack_is) begin
                            nxt_next = itm_reg.ack;
                            cs_next  = ST_FIN_WAIT2;
                        end
                        if (itm_reg.fin) begin
                            rnxt_next   = fin_next;
                            acknow_next = 1'b1;
                        end
                    end
                    ST_FIN_WAIT2: begin
                        if (itm_reg.fin) begin
                            rnxt_next   = fin_next;
                            acknow_next = 1'b1;
                            cs_next     = ST_TIME_WAIT;
                        end
                    end
                    ST_CLOSING: begin
                        if (itm_reg.has_ack && ack_is) begin
                            nxt_next = itm_reg.ack;
                            cs_next  = ST_TIME_WAIT;
                        end
                    end
                    ST_TIME_WAIT: begin
                        if (seq_lt(rnxt_reg, seg_end)) begin
                            rnxt_next = seg_end;
                        end
                        if (itm_reg.len != 16'd0) begin
                            acknow_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next                    = 1'b1;
                    out_next.conn_state_out           = cs_reg;
                    out_next.congestion_window_out    = cwnd_reg;
                    out_next.slow_start_threshold_out = ssth_reg;
                    out_next.send_window_out          = swnd_reg;
                    out_next.receive_next_out         = rnxt_reg;
                    out_next.release_up_to            = rel_reg ? itm_reg.ack : 32'd0;
                    out_next.release_valid            = rel_reg;
                    out_next.retransmit_request       = rexmit_reg;
                    out_next.ack_now                  = acknow_reg;
                    out_next.ack_delayed              = ackdly_reg;
                    out_next.persist_action           = persist_reg;
                    out_next.data_accepted            = accept_reg;
                    state_next                        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // The user sends configuration writes only while idle; not enforced.
        if (cfg.en) begin
            unique case (cfg.index)
                CFG_MSS:       mss_next   = cfg.data;
                CFG_QUICK_ACK: quick_next = cfg.data[0];
                CFG_DUP_THR:   thr_next   = cfg.data[3:0];
                CFG_INIT_RWND: begin
                    irw_next  = cfg.data;
                    rwnd_next = cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mss_reg       <= MSS_RESET;
            quick_reg     <= 1'b0;
            thr_reg       <= DUP_THR_RESET;
            irw_reg       <= INIT_RWND_RESET;
            cs_reg        <= ST_CLOSED;
            una_reg       <= 32'd0;
            nxt_reg       <= 32'd0;
            swnd_reg      <= 16'd0;
            wl1_reg       <= 32'd0;
            wl2_reg       <= 32'd0;
            cwnd_reg      <= {16'd0, MSS_RESET};
            ssth_reg      <= MAX_WINDOW;
            dup_reg       <= 16'd0;
            rnxt_reg      <= 32'd0;
            rwnd_reg      <= INIT_RWND_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mss_reg       <= mss_next;
            quick_reg     <= quick_next;
            thr_reg       <= thr_next;
            irw_reg       <= irw_next;
            cs_reg        <= cs_next;
            una_reg       <= una_next;
            nxt_reg       <= nxt_next;
            swnd_reg      <= swnd_next;
            wl1_reg       <= wl1_next;
            wl2_reg       <= wl2_next;
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            dup_reg       <= dup_next;
            rnxt_reg      <= rnxt_next;
            rwnd_reg      <= rwnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        itm_reg     <= itm_next;
        mode_reg    <= mode_next;
        upd_reg     <= upd_next;
        diva_reg    <= diva_next;
        divb_reg    <= divb_next;
        prod_reg    <= prod_next;
        rel_reg     <= rel_next;
        rexmit_reg  <= rexmit_next;
        acknow_reg  <= acknow_next;
        ackdly_reg  <= ackdly_next;
        persist_reg <= persist_next;
        accept_reg  <= accept_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

// ----- src/tcp_segment_receive_engine.sv -----
// Top level of the TCP segment receive engine for one connection.
//
// Input channel s_*: one item per segment header (operation 0), send pointer
// update (operation 1) or local state change (operation 2). Result channel
// m_*: exactly one result item per input item, in order, carrying the
// connection state, windows and the ack/release/retransmit/persist requests.
// cfg_*: register writes (index 0 mss, 1 quick ack, 2 dupack threshold,
// 3 initial receive window): the user writes only while idle, not enforced.
//
// Pointer updates, local state changes and dropped segments (closed, reset
// flag) pass the window step straight to the result register; segments
// without ACK also pass the data step, and ACK segments the ack step before
// it. A new ACK in linear increase and a fast retransmit also wait on the
// 32-step shared divider. One item is in the back end at a time; the front
// queue holds two more and keeps accepting meanwhile.
//
// Reset (aresetn low, synchronous) puts the connection in closed, clears
// the pointers, loads cwnd with 536 and the registers with their defaults.
// When m_ready stays low the result register holds its item; the back end
// stops before writing the next result and the front queue then fills.
`default_nettype none

module tcp_segment_receive_engine import tsre_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;
    cfg_wr_t     cfg;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Classify and buffer incoming items
    tsre_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // Shared divider for the Reno window arithmetic
    tsre_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Connection state, congestion control and result register
    tsre_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule

`default_nettype wire

// ----- src/tsre_checker.sv -----
// Port-level checker for the TCP segment receive engine, with its bind.
`default_nettype none

module tsre_checker import tsre_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire in_item_t    s_item,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire out_item_t   m_item,
    input wire logic        cfg_wr_en,
    input wire logic [1:0]  cfg_index,
    input wire logic [15:0] cfg_data
);

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_release_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.release_valid |-> m_item.release_up_to == 32'd0)
        else $error("release pointer without release");

    a_accept_acks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.data_accepted |-> m_item.ack_delayed)
        else $error("data accepted without delayed ack");

    a_persist_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.persist_action != 2'd3)
        else $error("bad persist action");

endmodule

bind tcp_segment_receive_engine tsre_checker u_tsre_checker (.*);

`default_nettype wire

// ----- verif/tcp_segment_receive_engine_checker.sv -----
// Checker: watches the engine channels, models the connection and compares each result item.
`timescale 1ns / 100ps

module tcp_segment_receive_engine_checker import tsre_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_item_t    s_item,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_item_t   m_item,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);

    logic [15:0] c_mss, c_irwnd;
    logic        c_quick;
    logic [3:0]  c_thr;

    logic [3:0]  cs;
    logic [31:0] snd_una, snd_nxt, snd_max;
    logic [15:0] snd_wnd, max_snd_wnd;
    logic [31:0] wl_seq, wl_ack;
    logic [31:0] cwnd, ssthresh;
    logic [15:0] dupacks;
    logic [31:0] rcv_nxt;
    logic [15:0] rcv_wnd;

    out_item_t   expected_results[$];
    out_item_t   res;

    function automatic logic lt32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [31:0] sat(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic run_segment(input in_item_t it);
        logic [7:0]  fl;
        logic        fin, hasack;
        logic [31:0] seq, ack, fin_next, mss, thr, m, segs, seg_end, size;
        logic [15:0] wnd, len;
        logic [63:0] unit, nc;
        fl = it.header_flags; seq = it.seq_number; ack = it.ack_number;
        wnd = it.advertised_window; len = it.payload_length;
        fin = fl[FL_FIN_BIT]; hasack = fl[FL_ACK_BIT];
        fin_next = seq + len + 1;
        mss = (c_mss == 0) ? 32'd1 : {16'd0, c_mss};
        thr = (c_thr == 0) ? 32'd1 : {28'd0, c_thr};
        if (cs == ST_CLOSED) return;
        if (fl[FL_RST_BIT]) begin
            if (cs > ST_CONNECTING) cs = ST_CLOSED;
            return;
        end
        if (hasack && cs != ST_TIME_WAIT) begin
            // peer window update
            if (lt32(wl_seq, seq) || (seq == wl_seq && (wl_ack == ack || lt32(wl_ack, ack)))) begin
                snd_wnd = wnd; wl_seq = seq; wl_ack = ack;
                if (wnd > max_snd_wnd) max_snd_wnd = wnd;
                res.persist_action = (wnd == 0) ? PA_LOAD : PA_CLEAR;
            end
            // ack processing, Reno
            if (ack == snd_una || lt32(ack, snd_una)) begin
                if (len == 0) begin
                    if (dupacks != 16'hFFFF) dupacks++;
                    if ({16'd0, dupacks} == thr) begin
                        m = (snd_wnd < cwnd) ? {16'd0, snd_wnd} : cwnd;
                        segs = m / 2 / mss;
                        if (segs < 2) segs = 2;
                        ssthresh = sat(64'(segs) * mss);
                        res.retransmit_request = 1;
                        cwnd = sat(64'(ssthresh) + 64'(mss) * dupacks);
                    end else if ({16'd0, dupacks} > thr) begin
                        cwnd = sat(64'(cwnd) + mss);
                        res.retransmit_request = 1;
                    end
                end else begin
                    dupacks = 0;
                end
            end else begin
                if ({16'd0, dupacks} >= thr && cwnd > ssthresh) cwnd = ssthresh;
                dupacks = 0;
                unit = mss;
                if (cwnd > ssthresh) unit = (64'(mss) * mss) / cwnd;
                nc = 64'(cwnd) + unit;
                if (nc > 64'(MAX_WINDOW)) nc = 64'(MAX_WINDOW);
                cwnd = nc[31:0];
                snd_una = ack;
                res.release_up_to = ack;
                res.release_valid = 1;
            end
            // in-order data
            if (len > 0) begin
                seg_end = seq + len;
                res.ack_delayed = 1;
                if (!((seg_end == rcv_nxt || lt32(seg_end, rcv_nxt)) || lt32(rcv_nxt, seq))) begin
                    size = seg_end - rcv_nxt;
                    rcv_nxt = seg_end;
                    rcv_wnd = (size >= rcv_wnd) ? 16'd0 : rcv_wnd - size[15:0];
                    if (c_quick) res.ack_now = 1;
                    if (cs <= ST_ESTABLISHED) res.data_accepted = 1;
                end
            end
        end
        case (cs)
            ST_CONNECTING: begin
                if (fl == FL_SYN_ACK && ack == snd_nxt + 1) begin
                    cs = ST_ESTABLISHED; rcv_nxt = seq + 1; snd_nxt = ack;
                    snd_wnd = wnd; snd_una = ack; res.ack_delayed = 1;
                    if (c_quick) res.ack_now = 1;
                end
            end
            ST_SYN_RCVD: begin
                if (hasack && ack == snd_nxt + 1) begin
                    cs = ST_ESTABLISHED; snd_nxt = ack;
                end
            end
            ST_ESTABLISHED, ST_CLOSE_WAIT: begin
                if (fin) begin
                    res.ack_now = 1; cs = ST_CLOSE_WAIT; rcv_nxt = fin_next;
                end
            end
            ST_LAST_ACK: if (hasack) cs = ST_CLOSED;
            ST_FIN_WAIT1: begin
                if (fin && hasack && ack == snd_nxt + 1) begin
                    snd_nxt++; cs = ST_TIME_WAIT;
                end else if (fin) begin
                    cs = ST_CLOSING;
                end else if (hasack && ack == snd_nxt + 1) begin
                    snd_nxt++; cs = ST_FIN_WAIT2;
                end
                if (fin) begin
                    rcv_nxt = fin_next; res.ack_now = 1;
                end
            end
            ST_FIN_WAIT2: begin
                if (fin) begin
                    rcv_nxt = fin_next; res.ack_now = 1; cs = ST_TIME_WAIT;
                end
            end
            ST_CLOSING: begin
                if (hasack && ack == snd_nxt + 1) begin
                    snd_nxt++; cs = ST_TIME_WAIT;
                end
            end
            ST_TIME_WAIT: begin
                if (lt32(rcv_nxt, seq + len)) rcv_nxt = seq + len;
                if (len > 0) res.ack_now = 1;
            end
            default: ;
        endcase
    endtask

    task automatic predict_item(input in_item_t it);
        logic [16:0] w;
        res = '0;
        case (it.operation)
            OP_SEGMENT: run_segment(it);
            OP_PTRS: begin
                snd_nxt = it.new_send_next; snd_max = it.new_send_max;
            end
            OP_LOCAL: begin
                w = rcv_wnd + it.payload_length;
                if (it.new_conn_state <= ST_TIME_WAIT) cs = it.new_conn_state;
                rcv_wnd = w[16] ? 16'hFFFF : w[15:0];
            end
            default: ;
        endcase
        res.conn_state_out = cs;
        res.congestion_window_out = cwnd;
        res.slow_start_threshold_out = ssthresh;
        res.send_window_out = snd_wnd;
        res.receive_next_out = rcv_nxt;
        expected_results.push_back(res);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            c_mss = MSS_RESET; c_quick = 0; c_thr = DUP_THR_RESET; c_irwnd = INIT_RWND_RESET;
            cs = ST_CLOSED; snd_una = 0; snd_nxt = 0; snd_max = 0;
            snd_wnd = 0; max_snd_wnd = 0; wl_seq = 0; wl_ack = 0;
            cwnd = {16'd0, MSS_RESET}; ssthresh = MAX_WINDOW; dupacks = 0;
            rcv_nxt = 0; rcv_wnd = INIT_RWND_RESET;
            expected_results.delete();
            fail_count = 0;
        end else begin
            // results first: a result can never belong to an item taken this edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_item);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_item) begin
                        $display("%0t: result mismatch expected %p actual %p", $time, want, m_item);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MSS:       c_mss = cfg_data;
                    CFG_QUICK_ACK: c_quick = cfg_data[0];
                    CFG_DUP_THR:   c_thr = cfg_data[3:0];
                    CFG_INIT_RWND: begin
                        c_irwnd = cfg_data; rcv_wnd = cfg_data;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_item(s_item);
        end
        pending_count = expected_results.size();
    end

endmodule

// ----- verif/tcp_segment_receive_engine_tb.sv -----
// Testbench top: clock, reset, configuration phases, item stimulus and verdict.
`timescale 1ns / 100ps

module tcp_segment_receive_engine_tb import tsre_pkg::*;;

    // operation code the engine does not use
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_item;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = CFG_MSS;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending_count;

    // idle odds in percent for each side
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // sequence space the stimulus tracks so most segments land in order
    logic [31:0] peer_seq, peer_ack;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    tcp_segment_receive_engine dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .cfg_wr_en, .cfg_index, .cfg_data
    );

    tcp_segment_receive_engine_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .cfg_wr_en, .cfg_index, .cfg_data, .fail_count, .pending_count
    );

    // receiver stalls: one decision per edge
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hold one item on the channel until taken; random sender gaps before it
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // engine is quiet only once nothing is owed and the divider has drained
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] fl,
                                           input logic [31:0] seq, input logic [31:0] ack,
                                           input logic [15:0] wnd, input logic [15:0] len,
                                           input logic [3:0] nst);
        in_item_t it;
        it.operation = op; it.header_flags = fl; it.seq_number = seq;
        it.ack_number = ack; it.advertised_window = wnd; it.payload_length = len;
        it.new_send_next = $urandom; it.new_send_max = $urandom; it.new_conn_state = nst;
        return it;
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it.operation         = 2'($urandom_range(3));
        it.header_flags      = 8'($urandom);
        it.seq_number        = $urandom;
        it.ack_number        = $urandom;
        it.advertised_window = 16'($urandom);
        it.payload_length    = 16'($urandom);
        it.new_send_next     = $urandom;
        it.new_send_max      = $urandom;
        it.new_conn_state    = 4'($urandom);
        return it;
    endfunction

    // mostly well-formed traffic on a live connection, some junk and state jumps
    function automatic in_item_t traffic_item();
        in_item_t it;
        int       pick;
        logic [15:0] len;
        pick = $urandom_range(99);
        if (pick < 6) return noise_item();
        if (pick < 12) begin
            return make_item(OP_LOCAL, 0, 0, 0, 0, 16'($urandom_range(4000)),
                             (pick < 11) ? 4'($urandom_range(2, 10)) : 4'($urandom_range(15)));
        end
        if (pick < 16) begin
            it = make_item(OP_PTRS, 0, 0, 0, 0, 0, 0);
            it.new_send_next = peer_ack + $urandom_range(3) - 1;
            return it;
        end
        if (pick < 40) begin
            // duplicate acks drive fast retransmit and recovery
            return make_item(OP_SEGMENT, 8'h10, peer_seq, peer_ack, 16'($urandom),
                             0, 0);
        end
        len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
        if (pick < 80) peer_ack = peer_ack + $urandom_range(3000);
        it = make_item(OP_SEGMENT, 8'h10 | 8'($urandom_range(15) == 0) | 8'($urandom_range(1) << 3),
                       peer_seq + (($urandom_range(9) == 0) ? 32'($urandom_range(4000)) - 2000 : 0),
                       peer_ack + (($urandom_range(19) == 0) ? 32'd1 : 32'd0),
                       ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom), len, 0);
        if ($urandom_range(49) == 0) it.header_flags = 8'($urandom);
        if (it.seq_number == peer_seq) peer_seq = peer_seq + len;
        return it;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_item(traffic_item());
    endtask

    initial begin
        send_item_directed();
    end

    task automatic send_item_directed();
        in_item_t it;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part on reset settings
        send_item(make_item(OP_SEGMENT, 8'h12, 0, 1, 100, 10, 0));       // closed: ignored
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 0, ST_LISTEN));
        send_item(make_item(OP_SEGMENT, 8'h12, 5, 1, 100, 0, 0));        // listen: ack processed, state kept
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 16'hFFFF, ST_CONNECTING));
        it = make_item(OP_PTRS, 0, 0, 0, 0, 0, 0);
        it.new_send_next = 32'hFFFF_FFFF; it.new_send_max = 32'hFFFF_FFFF;
        send_item(it);
        send_item(make_item(OP_SEGMENT, 8'h04, 0, 0, 0, 0, 0));          // rst while opening
        send_item(make_item(OP_SEGMENT, 8'h12, 32'hFFFF_FFF0, 0, 16'hFFFF, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 0, 0, 16'hFFFF, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 0, 16'd4000, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 0, 16'd4000, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 0, 16'd4000, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 0, 16'd4000, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'hFFFF_FFF1, 32'd5000, 16'd4000, 0, 0));
        send_item(make_item(OP_SEGMENT, 8'h19, 32'h0000_FFF0, 32'd5000, 16'd9, 0, 0)); // fin
        send_item(make_item(OP_SEGMENT, 8'h10, 0, 32'd6000, 16'd9, 5, 0));  // ack with payload
        send_item(make_item(OP_SEGMENT, 8'h00, 0, 0, 0, 5, 0));
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 100, 4'd15));          // unknown state ignored
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 100, ST_FIN_WAIT1));
        send_item(make_item(OP_SEGMENT, 8'h11, 32'd100, 32'd6000, 16'd1, 0, 0));
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 0, ST_LAST_ACK));
        send_item(make_item(OP_SEGMENT, 8'h10, 32'd100, 32'd6000, 16'd1, 0, 0));
        send_item(make_item(OP_UNUSED, 8'hFF, 0, 0, 0, 0, 0));           // unused operation
        send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 0, ST_ESTABLISHED));
        send_item(make_item(OP_SEGMENT, 8'h04, 0, 0, 0, 0, 0));          // rst closes
        wait_idle();

        // settings sweep: extremes, middles, random values and mss 1; each phase reopens a connection
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_MSS, 0); write_reg(CFG_QUICK_ACK, 1);
                   write_reg(CFG_DUP_THR, 0); write_reg(CFG_INIT_RWND, 0); end
                1: begin write_reg(CFG_MSS, 16'hFFFF); write_reg(CFG_QUICK_ACK, 0);
                   write_reg(CFG_DUP_THR, 15); write_reg(CFG_INIT_RWND, 16'hFFFF); end
                2: begin write_reg(CFG_MSS, 1460); write_reg(CFG_DUP_THR, 1);
                   write_reg(CFG_INIT_RWND, 2000); end
                3: begin write_reg(CFG_MSS, 536); write_reg(CFG_DUP_THR, 3);
                   write_reg(CFG_QUICK_ACK, 1); end
                4: begin write_reg(CFG_MSS, 16'($urandom_range(1, 9000)));
                   write_reg(CFG_DUP_THR, 16'($urandom_range(15)));
                   write_reg(CFG_INIT_RWND, 16'($urandom)); end
                default: begin write_reg(CFG_MSS, 1); write_reg(CFG_QUICK_ACK, 0); end
            endcase
            case (ph)
                0, 1:    begin send_idle_pct = 31; recv_idle_pct = 71; end
                2, 3:    begin send_idle_pct = 71; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            peer_seq = $urandom; peer_ack = $urandom;
            send_item(make_item(OP_LOCAL, 0, 0, 0, 0, 0, ST_CONNECTING));
            it = make_item(OP_PTRS, 0, 0, 0, 0, 0, 0);
            it.new_send_next = peer_ack - 1;
            send_item(it);
            send_item(make_item(OP_SEGMENT, FL_SYN_ACK, peer_seq, peer_ack, 16'($urandom), 0, 0));
            peer_seq = peer_seq + 1;
            random_phase(320);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    endtask

    initial begin
        #(5_000_000 * 12);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tsre_pkg.sv
src/tsre_front.sv
src/tsre_div.sv
src/tsre_back.sv
src/tcp_segment_receive_engine.sv
src/tsre_checker.sv
verif/tcp_segment_receive_engine_checker.sv
verif/tcp_segment_receive_engine_tb.sv
